// ===== design/tops_pkg.sv =====
package tops_pkg;

    localparam int COORD_W  = 32;              // Q16.16 coordinate
    localparam int DRAW_W   = 16;              // draw field width on the bus
    localparam int EDGE_W   = COORD_W + 1;     // vertex difference
    localparam int PROD_W   = 2 * EDGE_W;      // one cross-product term
    localparam int CROSS_W  = 68;              // cross component, signed
    localparam int NORM_W   = 30;              // normalized magnitude
    localparam int SQ_W     = 2 * NORM_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = 31;              // normal length
    localparam int QUO_W    = 31;              // unit normal, Q1.30
    localparam int P_W      = COORD_W + 1;     // base point before offset
    localparam int THICK_W  = 31;
    localparam int OFF_W    = 33;
    localparam int RES_W    = P_W + 2;         // point minus offset

    localparam int IN_W     = 9 * COORD_W + 3 * DRAW_W;
    localparam int OUT_W    = 3 * COORD_W;

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic [0:0] REG_THICKNESS = 1'b0;
    localparam logic [THICK_W-1:0] THICK_RESET = 31'd65536;

    // carried alongside the normal computation
    typedef struct packed {
        logic [2:0][P_W-1:0]    p;
        logic [THICK_W-1:0]     depth;
        logic [2:0]             neg;
        logic                   degen;
        logic [2:0][NORM_W-1:0] mag;
    } t_side;

    function automatic int job_width(int draw_bits);
        return 9 * COORD_W + 3 * (draw_bits + 1) + 6 * EDGE_W + THICK_W;
    endfunction

endpackage

// ===== design/tops_fifo.sv =====
module tops_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4     // power of two
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nempty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full   = (r_cnt == CNT_W'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end
endmodule

// ===== design/tops_front.sv =====
module tops_front #(
    parameter int DRAW_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tops_pkg::IN_W-1:0]     i_s_tdata,
    input  logic [tops_pkg::THICK_W-1:0]  i_thickness,
    output logic                          o_push,
    input  logic                          i_full,
    output logic [tops_pkg::job_width(DRAW_BITS)-1:0] o_job
);
    import tops_pkg::*;

    localparam int DW = DRAW_BITS;
    localparam int WW = DRAW_BITS + 1;

    typedef struct packed {
        logic [2:0][2:0][COORD_W-1:0]  vtx;
        logic [2:0][WW-1:0]            wgt;
        logic [1:0][2:0][EDGE_W-1:0]   edg;
        logic [THICK_W-1:0]            depth;
    } t_job;

    logic [IN_W-1:0]       r_tdata;
    logic                  r_vld;
    t_job                  job;
    logic [31:0]           ra_ext, rb_ext, rd_ext;
    logic [DW-1:0]         ra, rb, rd;
    logic [WW-1:0]         one;
    logic [THICK_W+DW-1:0] dprod;

    assign o_s_tready = !r_vld || !i_full;
    assign o_push     = r_vld && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) r_tdata <= i_s_tdata;
    end

    // draw bits above DRAW_BITS are dropped
    assign ra_ext = 32'(r_tdata[9*COORD_W +: DRAW_W]);
    assign rb_ext = 32'(r_tdata[9*COORD_W + DRAW_W +: DRAW_W]);
    assign rd_ext = 32'(r_tdata[9*COORD_W + 2*DRAW_W +: DRAW_W]);
    assign ra  = ra_ext[DW-1:0];
    assign rb  = rb_ext[DW-1:0];
    assign rd  = rd_ext[DW-1:0];
    assign one = {1'b1, {DW{1'b0}}};

    assign dprod = (THICK_W+DW)'(i_thickness) * (THICK_W+DW)'(rd);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                job.vtx[k][j] = r_tdata[(3*k+j)*COORD_W +: COORD_W];
            end
        end
        if (ra > rb) begin
            job.wgt[0] = WW'(ra - rb);
            job.wgt[1] = WW'(rb);
            job.wgt[2] = one - WW'(ra);
        end else begin
            job.wgt[0] = WW'(ra);
            job.wgt[1] = WW'(rb - ra);
            job.wgt[2] = one - WW'(rb);
        end
        for (int j = 0; j < 3; j++) begin
            job.edg[0][j] = EDGE_W'($signed(job.vtx[1][j])) - EDGE_W'($signed(job.vtx[0][j]));
            job.edg[1][j] = EDGE_W'($signed(job.vtx[2][j])) - EDGE_W'($signed(job.vtx[0][j]));
        end
        job.depth = dprod[DW +: THICK_W];
    end

    assign o_job = job;
endmodule

// ===== design/tops_back.sv =====
module tops_back #(
    parameter int DRAW_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tops_pkg::job_width(DRAW_BITS)-1:0] i_job,
    input  logic                          i_job_vld,
    output logic                          o_job_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tops_pkg::OUT_W-1:0]    o_m_tdata,
    output logic                          o_m_tuser
);
    import tops_pkg::*;

    localparam int DW  = DRAW_BITS;
    localparam int WW  = DRAW_BITS + 1;
    localparam int PW  = COORD_W + WW + 1;
    localparam int SW  = PW + 2;
    localparam int NST = 78;   // A,B,C, 7 norm, sq, sum, 31 sqrt, div load, 31 div, mul, rnd, out
    localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (DRAW_BITS - 1));

    typedef struct packed {
        logic [2:0][2:0][COORD_W-1:0]  vtx;
        logic [2:0][WW-1:0]            wgt;
        logic [1:0][2:0][EDGE_W-1:0]   edg;
        logic [THICK_W-1:0]            depth;
    } t_job;

    t_job                 job;
    logic                 w_adv;
    logic [NST-1:0]       r_vld;

    assign job        = i_job;
    assign w_adv      = !r_vld[NST-1] || i_m_tready;
    assign o_job_pop  = w_adv && i_job_vld;
    assign o_m_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_job_vld};
        end
    end

    // stage A: weight products and cross-product terms
    logic signed [PW-1:0]     r_a_wv [3][3];
    logic signed [PROD_W-1:0] r_a_pa [3];
    logic signed [PROD_W-1:0] r_a_pb [3];
    logic [THICK_W-1:0]       r_a_depth;
    logic signed [EDGE_W-1:0] e1 [3];
    logic signed [EDGE_W-1:0] e2 [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            e1[j] = $signed(job.edg[0][j]);
            e2[j] = $signed(job.edg[1][j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_a_wv[k][j] <= PW'($signed({1'b0, job.wgt[k]}))
                                  * PW'($signed(job.vtx[k][j]));
                end
            end
            r_a_pa[0] <= PROD_W'(e1[1]) * PROD_W'(e2[2]);
            r_a_pb[0] <= PROD_W'(e1[2]) * PROD_W'(e2[1]);
            r_a_pa[1] <= PROD_W'(e1[2]) * PROD_W'(e2[0]);
            r_a_pb[1] <= PROD_W'(e1[0]) * PROD_W'(e2[2]);
            r_a_pa[2] <= PROD_W'(e1[0]) * PROD_W'(e2[1]);
            r_a_pb[2] <= PROD_W'(e1[1]) * PROD_W'(e2[0]);
            r_a_depth <= job.depth;
        end
    end

    // stage B: base point rounded, cross components
    logic signed [SW-1:0]      s_rnd [3];
    logic signed [SW-1:0]      s_shr [3];
    logic signed [CROSS_W-1:0] r_b_c [3];
    t_side                     r_b_side;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            s_rnd[j] = SW'(r_a_wv[0][j]) + SW'(r_a_wv[1][j]) + SW'(r_a_wv[2][j]) + HALF;
            s_shr[j] = s_rnd[j] >>> DW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_b_c[i]      <= CROSS_W'(r_a_pa[i]) - CROSS_W'(r_a_pb[i]);
                r_b_side.p[i] <= s_shr[i][P_W-1:0];
            end
            r_b_side.depth <= r_a_depth;
            r_b_side.neg   <= '0;
            r_b_side.degen <= 1'b0;
            r_b_side.mag   <= '0;
        end
    end

    // stage C (norm index 0): sign and magnitude
    logic [CROSS_W-1:0] r_n_mag  [8][3];
    logic [CROSS_W-1:0] r_n_or   [8];
    t_side              r_n_side [8];
    logic [CROSS_W-1:0] c_mag    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_mag[i] = r_b_c[i][CROSS_W-1] ? CROSS_W'(-r_b_c[i]) : CROSS_W'(r_b_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_n_mag[0][i]     <= c_mag[i];
                r_n_side[0].neg[i] <= r_b_c[i][CROSS_W-1];
            end
            r_n_or[0]         <= c_mag[0] | c_mag[1] | c_mag[2];
            r_n_side[0].p     <= r_b_side.p;
            r_n_side[0].depth <= r_b_side.depth;
            r_n_side[0].degen <= (c_mag[0] | c_mag[1] | c_mag[2]) == '0;
            r_n_side[0].mag   <= '0;
        end
    end

    // common left shift until the largest magnitude fills the top bit
    for (genvar g = 0; g < 7; g++) begin : g_norm
        localparam int K = 64 >> g;
        logic zt;
        assign zt = (r_n_or[g][CROSS_W-1 -: K] == '0);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int i = 0; i < 3; i++) begin
                    r_n_mag[g+1][i] <= zt ? (r_n_mag[g][i] << K) : r_n_mag[g][i];
                end
                r_n_or[g+1]   <= zt ? (r_n_or[g] << K) : r_n_or[g];
                r_n_side[g+1] <= r_n_side[g];
            end
        end
    end

    // squares
    logic [SQ_W-1:0]   r_q_sq [3];
    t_side             r_q_side;
    logic [NORM_W-1:0] m30 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) m30[i] = r_n_mag[7][i][CROSS_W-1 -: NORM_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_q_sq[i]       <= SQ_W'(m30[i]) * SQ_W'(m30[i]);
                r_q_side.mag[i] <= m30[i];
            end
            r_q_side.p     <= r_n_side[7].p;
            r_q_side.depth <= r_n_side[7].depth;
            r_q_side.neg   <= r_n_side[7].neg;
            r_q_side.degen <= r_n_side[7].degen;
        end
    end

    // sum, then floor square root two radicand bits a stage
    logic [34:0]       r_r_rem  [32];
    logic [ROOT_W-1:0] r_r_root [32];
    logic [SUM_W-1:0]  r_r_x    [32];
    t_side             r_r_side [32];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r_rem[0]  <= '0;
            r_r_root[0] <= '0;
            r_r_x[0]    <= SUM_W'(r_q_sq[0]) + SUM_W'(r_q_sq[1]) + SUM_W'(r_q_sq[2]);
            r_r_side[0] <= r_q_side;
        end
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        logic [34:0] rem2, trial;
        logic        ge;
        assign rem2  = {r_r_rem[g][32:0], r_r_x[g][SUM_W-1 -: 2]};
        assign trial = {2'b00, r_r_root[g], 2'b01};
        assign ge    = rem2 >= trial;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_r_rem[g+1]  <= ge ? rem2 - trial : rem2;
                r_r_root[g+1] <= {r_r_root[g][ROOT_W-2:0], ge};
                r_r_x[g+1]    <= r_r_x[g] << 2;
                r_r_side[g+1] <= r_r_side[g];
            end
        end
    end

    // restoring divide mag * 2^30 / len, three lanes, one quotient bit a stage
    logic [ROOT_W-1:0] r_d_rem  [32][3];
    logic [QUO_W-1:0]  r_d_q    [32][3];
    logic [QUO_W-1:0]  r_d_bits [32][3];
    logic [ROOT_W-1:0] r_d_len  [32];
    t_side             r_d_side [32];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_d_rem[0][i]  <= ROOT_W'(r_r_side[31].mag[i][NORM_W-1:1]);
                r_d_q[0][i]    <= '0;
                r_d_bits[0][i] <= {r_r_side[31].mag[i][0], {(QUO_W-1){1'b0}}};
            end
            r_d_len[0]  <= r_r_root[31];
            r_d_side[0] <= r_r_side[31];
        end
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        logic [ROOT_W:0] r2 [3];
        logic            ge [3];
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                r2[i] = {r_d_rem[g][i], r_d_bits[g][i][QUO_W-1]};
                ge[i] = r2[i] >= {1'b0, r_d_len[g]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int i = 0; i < 3; i++) begin
                    r_d_rem[g+1][i]  <= ge[i] ? ROOT_W'(r2[i] - {1'b0, r_d_len[g]})
                                              : r2[i][ROOT_W-1:0];
                    r_d_q[g+1][i]    <= {r_d_q[g][i][QUO_W-2:0], ge[i]};
                    r_d_bits[g+1][i] <= r_d_bits[g][i] << 1;
                end
                r_d_len[g+1]  <= r_d_len[g];
                r_d_side[g+1] <= r_d_side[g];
            end
        end
    end

    // depth times unit normal, then round
    localparam int MP_W = THICK_W + QUO_W;
    logic [MP_W-1:0]  r_m_prod [3];
    t_side            r_m_side;
    logic [OFF_W-1:0] r_o_off  [3];
    t_side            r_o_side;
    logic [MP_W:0]    rnd [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = (MP_W+1)'(r_m_prod[i]) + (MP_W+1)'(64'd1 << 29);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_m_prod[i] <= MP_W'(r_d_side[31].depth) * MP_W'(r_d_q[31][i]);
                r_o_off[i]  <= rnd[i][30 +: OFF_W];
            end
            r_m_side <= r_d_side[31];
            r_o_side <= r_m_side;
        end
    end

    // output register: apply offset against the normal, saturate
    logic signed [RES_W-1:0] res [3];
    logic [COORD_W-1:0]      sat [3];
    logic [COORD_W-1:0]      r_pt [3];
    logic                    r_degen;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_o_side.degen) begin
                res[i] = RES_W'($signed(r_o_side.p[i]));
            end else if (r_o_side.neg[i]) begin
                res[i] = RES_W'($signed(r_o_side.p[i])) + $signed(RES_W'(r_o_off[i]));
            end else begin
                res[i] = RES_W'($signed(r_o_side.p[i])) - $signed(RES_W'(r_o_off[i]));
            end
            if (res[i][RES_W-1:COORD_W-1] == '0 || res[i][RES_W-1:COORD_W-1] == '1) begin
                sat[i] = res[i][COORD_W-1:0];
            end else if (res[i][RES_W-1]) begin
                sat[i] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                sat[i] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) r_pt[i] <= sat[i];
            r_degen <= r_o_side.degen;
        end
    end

    assign o_m_tdata = {r_pt[2], r_pt[1], r_pt[0]};
    assign o_m_tuser = r_degen;
endmodule

// ===== design/triangle_offset_point_sampler_top.sv =====
// Triangle offset point sampler. Each request carries a triangle (three Q16.16
// vertices) and three random fractions; the block returns one point drawn
// uniformly on the triangle through barycentric weights, pushed inward along
// the unit normal by depth_draw/2^DRAW_BITS of the thickness register, with
// each coordinate saturated to 32 bits. A zero-area triangle returns the
// unshifted point with the degenerate flag set in tuser. Rate: one request
// per clock while the output accepts results. A request passes through the
// input register and the request queue, then a 78-stage result pipeline
// whose depth is set by the 31-stage square root (two radicand bits a stage)
// and the 31-stage divider (one quotient bit a stage) that build the unit
// normal. The queue lets the input side keep taking requests while the
// output stalls, until it fills.
// thickness sits at APB byte address 0; reset value 1.0 (65536).
module triangle_offset_point_sampler_top #(
    parameter int DRAW_BITS = 16    // fraction bits of the draws, 8..31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request: first_x, first_y, first_z, second_x..z, third_x..z (32b each),
    // weight_one_draw, weight_two_draw, depth_draw (16b each), lowest first
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [335:0] i_s_tdata,
    // result tdata: point_x, point_y, point_z (32b each), lowest first
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,
    // result tuser: degenerate
    output logic        o_m_tuser,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tops_pkg::*;

    localparam int JW         = job_width(DRAW_BITS);
    localparam int QUEUE_DEPTH = 4;

    logic [THICK_W-1:0] r_thickness;
    logic               reg_hit;

    logic               push, full, pop, nempty;
    logic [JW-1:0]      job_in, job_out;

    // register decode: index is the word address
    assign reg_hit = (paddr[2] == REG_THICKNESS);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {1'b0, r_thickness} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thickness <= THICK_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_thickness <= pwdata[THICK_W-1:0];
        end
    end

    // front: registers the request, forms weights, edges and depth
    tops_front #(
        .DRAW_BITS (DRAW_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_thickness (r_thickness),
        .o_push      (push),
        .i_full      (full),
        .o_job       (job_in)
    );

    // short queue decoupling the front from the result pipeline
    tops_fifo #(
        .WIDTH (JW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (job_in),
        .o_full   (full),
        .i_pop    (pop),
        .o_nempty (nempty),
        .o_data   (job_out)
    );

    // back: base point, normal, offset; stalls only on the output side
    tops_back #(
        .DRAW_BITS (DRAW_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job_out),
        .i_job_vld  (nempty),
        .o_job_pop  (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );
endmodule
